// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types, opcodes, status codes and widths for the rational unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Result range: reduced numerator is a signed WIDTH-bit value and the
    // reduced denominator is at most 2^(WIDTH-1)-1.
    localparam int WIDTH = 32;

    localparam int PROD_W = 64;              // one full product
    localparam int ALU_W  = PROD_W + 2;      // signed working width
    localparam int CNT_W  = $clog2(PROD_W);  // division step counter
    localparam int SHF_W  = $clog2(PROD_W);  // common power of two in gcd

    localparam logic [3:0] OP_NORM = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_EQ   = 4'd5;
    localparam logic [3:0] OP_NE   = 4'd6;
    localparam logic [3:0] OP_LT   = 4'd7;
    localparam logic [3:0] OP_LE   = 4'd8;
    localparam logic [3:0] OP_GT   = 4'd9;
    localparam logic [3:0] OP_GE   = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (WIDTH - 1);

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               truth;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

// ===== hw/rtl/rau_mult.sv =====
// ----------------------------------------------------------------------------
// Rational unit multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module rau_mult
    import rau_pkg::*;
(
    input  logic              clk,
    input  logic [31:0]       x,
    input  logic [31:0]       y,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(x) * PROD_W'(y);
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/rau_alu.sv =====
// ----------------------------------------------------------------------------
// Rational unit adder
// Shared two's complement add or subtract at the working width.
// ----------------------------------------------------------------------------
module rau_alu
    import rau_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] res
);

    assign res = req.a + (req.b ^ {ALU_W{req.sub}}) + ALU_W'(req.sub);

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Normalize, add, subtract, multiply, divide and compare signed fractions.
// ----------------------------------------------------------------------------
// Usage: one request channel (req_valid, req_ready, req) carries an opcode
// and two fractions a and b; one response channel (rsp_valid, rsp_ready,
// rsp) returns the reduced result, the comparison outcome and a status.
// Each transaction on the request side yields exactly one response.
// The block works on one transaction at a time and req_ready is high only
// while it is idle. A request passes through three products on a shared
// registered multiplier, a few passes through a shared adder, a binary gcd
// loop that uses the same adder, and two 64-step restoring divisions.
// Compares finish after the add and skip the gcd and the divisions, so
// arithmetic operations take longer, set mostly by the gcd loop and the
// 128 division steps. A divide by zero or an unused opcode goes straight
// from acceptance to the response stage and skips all of these steps.
// The response sits in an output register; if the receiver stalls, the
// finished result waits there and the sequencer holds in its last state.
// Reset clears the sequencer and the response valid flag; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_M4   = 4'd4;
    localparam logic [3:0] S_NEG1 = 4'd5;
    localparam logic [3:0] S_NEG2 = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_ABS  = 4'd8;
    localparam logic [3:0] S_GCD  = 4'd9;
    localparam logic [3:0] S_GSHL = 4'd10;
    localparam logic [3:0] S_DIVN = 4'd11;
    localparam logic [3:0] S_DIVD = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0] state_reg, state_next;

    // Operands in sign and magnitude form after normalization.
    logic [3:0]  op_reg;
    logic [31:0] an_mag_reg, ad_reg, bn_mag_reg, bd_reg;
    logic        an_neg_reg, bn_neg_reg;

    logic [PROD_W-1:0] p1_reg, p2_reg, p3_reg;
    logic [ALU_W-1:0]  lhs_reg, rhs_reg, sum_reg;

    // Result magnitude, denominator and sign being reduced.
    logic [PROD_W-1:0] mag_reg, den_reg;
    logic              neg_reg;

    logic [PROD_W-1:0] gx_reg, gy_reg;
    logic [SHF_W-1:0]  gk_reg;
    logic [PROD_W-1:0] dq_reg, dr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic signed [31:0] rn_reg;
    logic [30:0]        rd_reg;
    logic               tr_reg;
    logic [1:0]         st_reg;

    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic [31:0]       mx, my;
    logic [PROD_W-1:0] prod;
    alu_req_t          alu_req;
    logic [ALU_W-1:0]  alu_res;

    logic              accept;
    logic [31:0]       a_num_abs, a_den_abs, b_num_abs;
    logic [PROD_W-1:0] div_try;
    logic              div_bit;
    logic [PROD_W-1:0] div_rem;
    logic [PROD_W-1:0] div_q;
    logic              is_cmp;
    logic              eq, lt;
    logic              ovf;

    rau_mult u_mult (
        .clk  (clk),
        .x    (mx),
        .y    (my),
        .prod (prod)
    );

    rau_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign a_num_abs = req.a_num[31] ? 32'(-req.a_num) : req.a_num;
    assign a_den_abs = req.a_den[31] ? 32'(-req.a_den) : req.a_den;
    assign b_num_abs = req.b_num[31] ? 32'(-req.b_num) : req.b_num;

    assign is_cmp = (op_reg inside {[OP_EQ:OP_GE]});

    // The multiplier operands follow the product schedule.
    always_comb
    begin
        mx = ad_reg;
        my = bd_reg;
        case (state_reg)
            S_M1:
            begin
                mx = an_mag_reg;
                my = (op_reg == OP_MUL) ? bn_mag_reg : bd_reg;
            end
            S_M2:
            begin
                mx = bn_mag_reg;
                my = ad_reg;
            end
            default:
            begin
                mx = ad_reg;
                my = bd_reg;
            end
        endcase
    end

    // Restoring division step: shift in the next dividend bit, try g.
    assign div_try = {dr_reg[PROD_W-2:0], dq_reg[PROD_W-1]};
    assign div_bit = ~alu_res[ALU_W-1];
    assign div_rem = div_bit ? alu_res[PROD_W-1:0] : div_try;
    assign div_q   = {dq_reg[PROD_W-2:0], div_bit};

    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_NEG1:
            begin
                alu_req.b   = {2'b00, p1_reg};
                alu_req.sub = an_neg_reg;
            end
            S_NEG2:
            begin
                alu_req.b   = {2'b00, p2_reg};
                alu_req.sub = bn_neg_reg ^ (op_reg != OP_ADD);
            end
            S_ADD:
            begin
                alu_req.a = lhs_reg;
                alu_req.b = rhs_reg;
            end
            S_ABS:
            begin
                alu_req.b   = sum_reg;
                alu_req.sub = sum_reg[ALU_W-1];
            end
            S_GCD:
            begin
                alu_req.a   = {2'b00, gx_reg};
                alu_req.b   = {2'b00, gy_reg};
                alu_req.sub = 1'b1;
            end
            S_DIVN, S_DIVD:
            begin
                alu_req.a   = {2'b00, div_try};
                alu_req.b   = {2'b00, gy_reg};
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    assign eq = (sum_reg == '0);
    assign lt = sum_reg[ALU_W-1];

    assign ovf = (neg_reg ? (mag_reg > HALF) : (mag_reg > HALF - 1'b1))
              || (den_reg > HALF - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode > OP_GE)
                        state_next = S_DONE;
                    else if (req.opcode == OP_DIV && req.b_num == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_M1;
                end
            end
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_NEG1;
            S_NEG1:
            begin
                if (op_reg inside {OP_NORM, OP_MUL, OP_DIV})
                    state_next = S_GCD;
                else
                    state_next = S_NEG2;
            end
            S_NEG2: state_next = S_ADD;
            S_ADD:  state_next = is_cmp ? S_DONE : S_ABS;
            S_ABS:  state_next = S_GCD;
            S_GCD:
            begin
                if (gx_reg == '0)
                    state_next = S_GSHL;
            end
            S_GSHL:
            begin
                if (gk_reg == '0)
                    state_next = S_DIVN;
            end
            S_DIVN:
            begin
                if (cnt_reg == '1)
                    state_next = S_DIVD;
            end
            S_DIVD:
            begin
                if (cnt_reg == '1)
                    state_next = S_FIN;
            end
            S_FIN:  state_next = S_DONE;
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg     <= req.opcode;
                    an_mag_reg <= a_num_abs;
                    an_neg_reg <= req.a_num[31] ^ req.a_den[31];
                    ad_reg     <= (req.a_den == '0) ? 32'd1 : a_den_abs;
                    bn_mag_reg <= b_num_abs;
                    bn_neg_reg <= req.b_num[31];
                    bd_reg     <= (req.b_den == '0) ? 32'd1 : {1'b0, req.b_den};
                    rn_reg     <= '0;
                    rd_reg     <= '0;
                    tr_reg     <= 1'b0;
                    st_reg     <= (req.opcode == OP_DIV && req.b_num == '0)
                                  ? ST_DIV0 : ST_OK;
                end
            end
            S_M2: p1_reg <= prod;
            S_M3: p2_reg <= prod;
            S_M4: p3_reg <= prod;
            S_NEG1:
            begin
                lhs_reg <= alu_res;
                gk_reg  <= '0;
                case (op_reg)
                    OP_NORM:
                    begin
                        mag_reg <= PROD_W'(an_mag_reg);
                        den_reg <= PROD_W'(ad_reg);
                        neg_reg <= an_neg_reg;
                        gx_reg  <= PROD_W'(an_mag_reg);
                        gy_reg  <= PROD_W'(ad_reg);
                    end
                    OP_MUL:
                    begin
                        mag_reg <= p1_reg;
                        den_reg <= p3_reg;
                        neg_reg <= an_neg_reg ^ bn_neg_reg;
                        gx_reg  <= p1_reg;
                        gy_reg  <= p3_reg;
                    end
                    OP_DIV:
                    begin
                        mag_reg <= p1_reg;
                        den_reg <= p2_reg;
                        neg_reg <= an_neg_reg ^ bn_neg_reg;
                        gx_reg  <= p1_reg;
                        gy_reg  <= p2_reg;
                    end
                    default:
                    begin
                        neg_reg <= 1'b0;
                    end
                endcase
            end
            S_NEG2: rhs_reg <= alu_res;
            S_ADD:
            begin
                sum_reg <= alu_res;
                case (op_reg)
                    OP_EQ:   tr_reg <= (alu_res == '0);
                    OP_NE:   tr_reg <= (alu_res != '0);
                    OP_LT:   tr_reg <= alu_res[ALU_W-1];
                    OP_LE:   tr_reg <= alu_res[ALU_W-1] || (alu_res == '0);
                    OP_GT:   tr_reg <= !alu_res[ALU_W-1] && (alu_res != '0);
                    OP_GE:   tr_reg <= !alu_res[ALU_W-1];
                    default: tr_reg <= 1'b0;
                endcase
            end
            S_ABS:
            begin
                mag_reg <= alu_res[PROD_W-1:0];
                den_reg <= p3_reg;
                neg_reg <= lt && !eq;
                gx_reg  <= alu_res[PROD_W-1:0];
                gy_reg  <= p3_reg;
            end
            S_GCD:
            begin
                // Binary gcd; the larger odd value is replaced by the difference.
                if (gx_reg != '0)
                begin
                    if (!gx_reg[0] && !gy_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        gk_reg <= gk_reg + 1'b1;
                    end
                    else if (!gx_reg[0])
                        gx_reg <= gx_reg >> 1;
                    else if (!gy_reg[0])
                        gy_reg <= gy_reg >> 1;
                    else if (alu_res[ALU_W-1])
                    begin
                        gx_reg <= gy_reg;
                        gy_reg <= gx_reg;
                    end
                    else
                        gx_reg <= alu_res[PROD_W-1:0];
                end
            end
            S_GSHL:
            begin
                if (gk_reg != '0)
                begin
                    gy_reg <= gy_reg << 1;
                    gk_reg <= gk_reg - 1'b1;
                end
                else
                begin
                    dq_reg  <= mag_reg;
                    dr_reg  <= '0;
                    cnt_reg <= '0;
                end
            end
            S_DIVN:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    mag_reg <= div_q;
                    dq_reg  <= den_reg;
                    dr_reg  <= '0;
                end
                else
                begin
                    dq_reg <= div_q;
                    dr_reg <= div_rem;
                end
            end
            S_DIVD:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                dq_reg  <= div_q;
                dr_reg  <= div_rem;
                if (cnt_reg == '1)
                    den_reg <= div_q;
            end
            S_FIN:
            begin
                if (ovf)
                begin
                    st_reg <= ST_OVF;
                end
                else
                begin
                    rn_reg <= neg_reg ? -mag_reg[31:0] : mag_reg[31:0];
                    rd_reg <= den_reg[30:0];
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_reg.res_num <= rn_reg;
                    rsp_reg.res_den <= rd_reg;
                    rsp_reg.truth   <= tr_reg;
                    rsp_reg.status  <= st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== tb/rational_arithmetic_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives normalize, arithmetic and compare requests through the request
// channel and checks every response against a predictor built on exact
// double-width fraction arithmetic with Euclidean reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test
    import rau_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 175;
    localparam int DRAIN_CYCLES   = 500;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    rational_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Requests waiting to be offered, and the responses the predictor expects.
    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    // Idle percentages of the sender and the receiver; the initial block
    // changes them from phase to phase.
    int sender_idle_pct;
    int receiver_stall_pct;
    // Cycles left of a forced long receiver hold-off.
    int hold_off_cycles;

    int error_count;
    int checked_count;
    int accepted_count;
    int idle_cycles;
    int op_seen[16];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Euclidean gcd on 64-bit magnitudes.
    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduces num/den and packs it, or flags overflow when it does not fit.
    function automatic rsp_t reduce_fraction(logic signed [63:0] num, logic [63:0] den);
        rsp_t r;
        logic neg;
        logic [63:0] mag;
        logic [63:0] g;
        logic [63:0] lim;
        r = '0;
        neg = num < 0;
        mag = neg ? -num : num;
        g = euclid_gcd(mag, den);
        mag = mag / g;
        den = den / g;
        lim = 64'd1 << (WIDTH - 1);
        if (mag == 0)
            neg = 1'b0;
        if ((neg ? mag > lim : mag > lim - 1) || den > lim - 1)
        begin
            r.status = ST_OVF;
            return r;
        end
        r.res_num = neg ? -mag[31:0] : mag[31:0];
        r.res_den = den[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    // Computes the response the unit must give for one request.
    function automatic rsp_t predict_fraction_op(req_t q);
        rsp_t r;
        logic signed [63:0] an;
        logic signed [63:0] ad;
        logic signed [63:0] bn;
        logic signed [63:0] bd;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] n;
        logic signed [63:0] d;
        r = '0;
        an = q.a_num;
        ad = q.a_den;
        bn = q.b_num;
        bd = {33'd0, q.b_den};
        // A zero denominator counts as one; a negative a_den moves its sign up.
        if (ad == 0)
            ad = 1;
        if (ad < 0)
        begin
            ad = -ad;
            an = -an;
        end
        if (bd == 0)
            bd = 1;
        lhs = an * bd;
        rhs = bn * ad;
        case (q.opcode)
            OP_NORM: r = reduce_fraction(an, ad);
            OP_ADD:  r = reduce_fraction(lhs + rhs, ad * bd);
            OP_SUB:  r = reduce_fraction(lhs - rhs, ad * bd);
            OP_MUL:  r = reduce_fraction(an * bn, ad * bd);
            OP_DIV:
            begin
                if (bn == 0)
                    r.status = ST_DIV0;
                else
                begin
                    n = lhs;
                    d = rhs;
                    if (d < 0)
                    begin
                        d = -d;
                        n = -n;
                    end
                    r = reduce_fraction(n, d);
                end
            end
            OP_EQ: r.truth = lhs == rhs;
            OP_NE: r.truth = lhs != rhs;
            OP_LT: r.truth = lhs < rhs;
            OP_LE: r.truth = lhs <= rhs;
            OP_GT: r.truth = lhs > rhs;
            OP_GE: r.truth = lhs >= rhs;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Driver: presents the head of the queue and keeps it until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (!req_valid || req_ready)
            begin
                if (req_valid)
                    void'(pending_reqs.pop_front());
                // After a transaction the next item may go up in the same step.
                if (req_valid && pending_reqs.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_reqs[0];
                end
                else if (!req_valid && pending_reqs.size() > 0 &&
                         $urandom_range(99) >= sender_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_reqs[0];
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Predicts each accepted request at the edge where it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            expected_rsps.push_back(predict_fraction_op(req));
            accepted_count <= accepted_count + 1;
            op_seen[req.opcode] <= op_seen[req.opcode] + 1;
        end
    end

    // Receiver ready, with random stalls and the long forced hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= $urandom_range(99) >= receiver_stall_pct;
    end

    // Monitor: compares each response with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                error_count <= error_count + 1;
                if (error_count < 10)
                    $display("ERROR: unexpected response num=%0d den=%0d truth=%0b st=%0d",
                             rsp.res_num, rsp.res_den, rsp.truth, rsp.status);
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                checked_count <= checked_count + 1;
                if (rsp.res_num !== exp_rsp.res_num || rsp.res_den !== exp_rsp.res_den ||
                    rsp.truth !== exp_rsp.truth || rsp.status !== exp_rsp.status)
                begin
                    error_count <= error_count + 1;
                    if (error_count < 10)
                        $display("ERROR: expected %0d/%0d t=%0b s=%0d, got %0d/%0d t=%0b s=%0d",
                                 exp_rsp.res_num, exp_rsp.res_den, exp_rsp.truth,
                                 exp_rsp.status, rsp.res_num, rsp.res_den, rsp.truth,
                                 rsp.status);
                end
            end
        end
    end

    // Watchdog: counts cycles without any transaction on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("rational_arithmetic_unit verification failed");
                $finish;
            end
        end
    end

    // Random 32-bit value biased toward extremes and small magnitudes, which
    // keeps many results in range instead of overflowing.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(signed'($urandom_range(6)) - 3);
            3, 4: return 32'(signed'($urandom_range(2000)) - 1000);
            5: return 32'(signed'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t make_request(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                                          logic [31:0] bn, logic [30:0] bd);
        req_t q;
        q.opcode = op;
        q.a_num = an;
        q.a_den = ad;
        q.b_num = bn;
        q.b_den = bd;
        return q;
    endfunction

    task automatic queue_random(int count);
        logic [3:0] op;
        logic [31:0] bd;
        for (int i = 0; i < count; i++)
        begin
            // Mostly valid opcodes; a few unused ones.
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                            : 4'($urandom_range(10));
            bd = pick_word();
            pending_reqs.push_back(make_request(op, pick_word(), pick_word(),
                                                pick_word(), bd[30:0]));
        end
    endtask

    task automatic run_phase(int sender_pct, int receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
        queue_random(PHASE_ITEMS);
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        checked_count = 0;
        accepted_count = 0;
        idle_cycles = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, zero denominators, negative a_den with
        // the most negative value, divide by zero, exact overflow edge and
        // an unused opcode. The receiver first holds off for a long stretch
        // while the sender keeps offering, so the unit fills and stalls.
        hold_off_cycles = 3000;
        pending_reqs.push_back(make_request(OP_NORM, 32'd6, 32'hffff_fffc, 32'd0, 31'd1));
        pending_reqs.push_back(make_request(OP_NORM, 32'h8000_0000, 32'hffff_ffff,
                                            32'd0, 31'd0));
        pending_reqs.push_back(make_request(OP_NORM, 32'd5, 32'h8000_0000, 32'd0, 31'd1));
        pending_reqs.push_back(make_request(OP_NORM, 32'd0, 32'd0, 32'd0, 31'd0));
        pending_reqs.push_back(make_request(OP_NORM, 32'h7fff_ffff, 32'd0, 32'd0, 31'd0));
        pending_reqs.push_back(make_request(OP_ADD, 32'd1, 32'd2, 32'd1, 31'd3));
        pending_reqs.push_back(make_request(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 31'd1));
        pending_reqs.push_back(make_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd0, 31'd0));
        pending_reqs.push_back(make_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 31'd1));
        pending_reqs.push_back(make_request(OP_SUB, 32'd3, 32'd4, 32'd3, 31'd4));
        pending_reqs.push_back(make_request(OP_MUL, 32'h8000_0000, 32'h8000_0000,
                                            32'h8000_0000, 31'h7fff_ffff));
        pending_reqs.push_back(make_request(OP_MUL, 32'hffff_ffff, 32'd1, 32'h8000_0000,
                                            31'd1));
        pending_reqs.push_back(make_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff,
                                            32'h7fff_ffff, 31'h7fff_ffff));
        pending_reqs.push_back(make_request(OP_DIV, 32'd7, 32'd3, 32'd0, 31'd5));
        pending_reqs.push_back(make_request(OP_DIV, 32'd1, 32'd2, 32'hffff_fffd, 31'd4));
        pending_reqs.push_back(make_request(OP_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff,
                                            31'd1));
        pending_reqs.push_back(make_request(OP_EQ, 32'd1, 32'd2, 32'd2, 31'd4));
        pending_reqs.push_back(make_request(OP_NE, 32'd1, 32'd2, 32'd2, 31'd4));
        pending_reqs.push_back(make_request(OP_LT, 32'h8000_0000, 32'd1, 32'h7fff_ffff,
                                            31'h7fff_ffff));
        pending_reqs.push_back(make_request(OP_LE, 32'd1, 32'hffff_ffff, 32'hffff_ffff,
                                            31'd1));
        pending_reqs.push_back(make_request(OP_GT, 32'h7fff_ffff, 32'd1, 32'h8000_0000,
                                            31'd1));
        pending_reqs.push_back(make_request(OP_GE, 32'd0, 32'd0, 32'd0, 31'd0));
        pending_reqs.push_back(make_request(4'd15, 32'hffff_ffff, 32'hffff_ffff,
                                            32'hffff_ffff, 31'h7fff_ffff));
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
            @(posedge clk);

        run_phase(0, 0);
        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(23, 23);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d responses from %0d requests over four idle mixes.",
                 checked_count, accepted_count);
        $display("Opcode counts: norm %0d add %0d sub %0d mul %0d div %0d compares %0d",
                 op_seen[OP_NORM], op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
                 op_seen[OP_DIV], op_seen[OP_EQ] + op_seen[OP_NE] + op_seen[OP_LT] +
                 op_seen[OP_LE] + op_seen[OP_GT] + op_seen[OP_GE]);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end
endmodule

// ===== rational_arithmetic_unit.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_mult.sv
hw/rtl/rau_alu.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
